// ===== src/sss_pkg.sv =====
// ----------------------------------------------------------------------------
// sss_pkg: shared types, constants and helpers of the selective scan block
// Q16.16 rounding and saturation, sequencer states, small constant tables.
// ----------------------------------------------------------------------------
package sss_pkg;

    localparam int DEF_STATE_ELEMS = 16;

    // ln 2 in Q16.16 and half of it for the range reduction
    localparam int LN2_Q      = 45426;
    localparam int HALF_LN2_Q = 22713;
    localparam int Q_ONE      = 65536;
    // floor(2^31 / LN2_Q); quotient estimate is off by one at most
    localparam int K_RECIP    = 47274;
    localparam int K_SHIFT    = 31;
    // shift of the Horner divisor reciprocals
    localparam int H_SHIFT    = 24;
    localparam int H_TERMS    = 6;

    localparam logic signed [67:0] W_MAX = 68'sd2147483647;
    localparam logic signed [67:0] W_MIN = -68'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE,
        S_IDX,
        S_X,
        S_K,
        S_KF,
        S_HD,
        S_HF,
        S_EXP,
        S_DAH,
        S_DTB,
        S_DBU,
        S_CH,
        S_DU,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [31:0] val;
        logic               clip;
    } t_sat;

    function automatic t_sat sat_wide(input logic signed [67:0] v);
        t_sat s;
        if (v > W_MAX) begin
            s.val  = 32'sh7fffffff;
            s.clip = 1'b1;
        end else if (v < W_MIN) begin
            s.val  = 32'sh80000000;
            s.clip = 1'b1;
        end else begin
            s.val  = v[31:0];
            s.clip = 1'b0;
        end
        return s;
    endfunction

    // Q16.16 product: add half an LSB, floor shift, saturate
    function automatic t_sat q_round(input logic signed [67:0] prod);
        logic signed [67:0] v;
        v = (prod + 68'sd32768) >>> 16;
        return sat_wide(v);
    endfunction

    function automatic t_sat q_add(input logic signed [31:0] a,
                                   input logic signed [31:0] b);
        logic signed [67:0] v;
        v = 68'(a) + 68'(b);
        return sat_wide(v);
    endfunction

    // floor(2^H_SHIFT / i) for the Horner divisors
    function automatic logic [24:0] h_recip(input logic [2:0] i);
        logic [24:0] m;
        unique case (i)
            3'd1:    m = 25'd16777216;
            3'd2:    m = 25'd8388608;
            3'd3:    m = 25'd5592405;
            3'd4:    m = 25'd4194304;
            3'd5:    m = 25'd3355443;
            3'd6:    m = 25'd2796202;
            default: m = 25'd0;
        endcase
        return m;
    endfunction

    // scale the series result by 2^k
    function automatic t_sat exp_scale(input logic signed [19:0] p,
                                       input logic signed [17:0] k);
        t_sat               s;
        logic signed [67:0] v;
        logic signed [17:0] n;
        v = 68'sd0;
        n = -k;
        s.val  = 32'sd0;
        s.clip = 1'b0;
        if (k >= 18'sd0) begin
            if (k > 18'sd31) begin
                s.val  = 32'sh7fffffff;
                s.clip = 1'b1;
            end else begin
                v = 68'(p) <<< k[4:0];
                s = sat_wide(v);
            end
        end else if (n <= 18'sd40) begin
            v = (68'(p) + (68'sd1 <<< (n[5:0] - 6'd1))) >>> n[5:0];
            s.val  = v[31:0];
        end
        return s;
    endfunction

endpackage

// ===== src/sss_in_if.sv =====
// ----------------------------------------------------------------------------
// sss_in_if: input item channel of the selective scan
// valid/ready handshake carrying one state element of one time step.
// ----------------------------------------------------------------------------
interface sss_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] step_size;
    logic signed [31:0] sample_in;
    logic signed [31:0] decay_coef;
    logic signed [31:0] drive_coef;
    logic signed [31:0] read_coef;
    logic signed [31:0] skip_weight;
    logic signed [31:0] start_state;
    logic               first_step;
    logic [3:0]         elem_index;
    logic               step_end;

    modport source (output valid, step_size, sample_in, decay_coef, drive_coef,
                    read_coef, skip_weight, start_state, first_step, elem_index,
                    step_end, input ready);
    modport sink   (input valid, step_size, sample_in, decay_coef, drive_coef,
                    read_coef, skip_weight, start_state, first_step, elem_index,
                    step_end, output ready);
endinterface

// ===== src/sss_out_if.sv =====
// ----------------------------------------------------------------------------
// sss_out_if: result item channel of the selective scan
// valid/ready handshake carrying the updated state and step output.
// ----------------------------------------------------------------------------
interface sss_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_state;
    logic signed [31:0] out_value;
    logic               out_valid;
    logic               saturated;

    modport source (output valid, new_state, out_value, out_valid, saturated,
                    input ready);
    modport sink   (input valid, new_state, out_value, out_valid, saturated,
                    output ready);
endinterface

// ===== src/selective_state_space_scan.sv =====
// ----------------------------------------------------------------------------
// selective_state_space_scan: one-channel selective state-space scan, Q16.16
// One shared 34x34 multiplier under a sequencer updates one hidden element
// per item and accumulates the step output.
// ----------------------------------------------------------------------------
// Sequence: IDX, X, K, KF, HD and HF per term of the six-term exponential
//   series, EXP, DAH, DTB, DBU, CH, DU on a step_end item only, then OUT.
//   IDX repeats per modulo reduction of elem_index when STATE_ELEMS < 16.
// Items: a new item is taken only from IDLE, once the last result is taken.
// Reset (i_rst_n low, synchronous): sequencer idle, output sum cleared.
//   The hidden-state memory is not cleared; elements are valid once written.
// ----------------------------------------------------------------------------
module selective_state_space_scan #(
    parameter int STATE_ELEMS = sss_pkg::DEF_STATE_ELEMS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sss_in_if.sink        i_in,
    sss_out_if.source     o_out
);
    import sss_pkg::*;

    localparam int AW = (STATE_ELEMS > 1) ? $clog2(STATE_ELEMS) : 1;

    // sequencer
    t_state r_state, n_state;

    // latched item fields
    logic signed [31:0] r_dt, r_u, r_a, r_b, r_c, r_d, r_h0;
    logic               r_first, r_last;
    logic [3:0]         r_idx;

    // shared multiplier and its operand select
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] r_prod;

    // hidden-state memory
    logic signed [31:0] mem [STATE_ELEMS];
    logic signed [31:0] r_rd;
    logic [AW-1:0]      addr;
    logic               mem_we;

    // exponential working registers
    logic signed [33:0] r_n;     // x + half ln2
    logic signed [17:0] r_q;     // quotient estimate
    logic signed [17:0] r_k;     // power of two
    logic signed [16:0] r_r;     // reduced argument
    logic signed [19:0] r_p;     // series value
    logic signed [19:0] r_t;     // scaled product before division by i
    logic [2:0]         r_i;     // series term

    logic signed [31:0] r_dah, r_sum;
    logic signed [31:0] r_new_state, r_out_value;
    logic               r_flag;

    // combinational datapath pieces
    t_sat               qr, ad, ad2, ex;
    logic signed [33:0] x_n;
    logic signed [35:0] kf_rem;
    logic signed [17:0] kf_k;
    logic signed [35:0] kf_r;
    logic signed [67:0] hd_full;
    logic signed [19:0] hf_q;
    logic signed [21:0] hf_rem;
    logic signed [19:0] hf_qc;
    logic signed [19:0] hf_p;
    logic signed [31:0] hprev;

    assign addr  = AW'(r_idx);
    assign hprev = r_first ? r_h0 : r_rd;

    always_comb begin
        qr      = q_round(r_prod);
        x_n     = 34'(qr.val) + 34'(HALF_LN2_Q);
        // remainder against the quotient estimate, then one-step correction
        kf_rem  = 36'(r_n) - 36'(r_q) * 36'(LN2_Q);
        kf_k    = r_q;
        if (kf_rem < 36'sd0) begin
            kf_k   = r_q - 18'sd1;
            kf_rem = kf_rem + 36'(LN2_Q);
        end else if (kf_rem >= 36'(LN2_Q)) begin
            kf_k   = r_q + 18'sd1;
            kf_rem = kf_rem - 36'(LN2_Q);
        end
        kf_r    = kf_rem - 36'(HALF_LN2_Q);
        // Horner: floor((p*r + i*2^15) / 2^16), then floor(./i) by reciprocal
        hd_full = (r_prod + 68'(r_i) * 68'sd32768) >>> 16;
        hf_q    = r_prod[43:24];
        hf_rem  = 22'(r_t) - 22'(hf_q) * 22'(r_i);
        hf_qc   = hf_q;
        if (hf_rem < 22'sd0) begin
            hf_qc = hf_q - 20'sd1;
        end else if (hf_rem >= 22'(r_i)) begin
            hf_qc = hf_q + 20'sd1;
        end
        hf_p    = 20'(Q_ONE) + hf_qc;
        ex      = exp_scale(r_p, r_k);
        ad      = q_add(r_dah, qr.val);   // h on DBU
        ad2     = q_add(r_sum, qr.val);   // sum + c*h, or y on DU
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid) n_state = S_IDX;
            S_IDX:  if (int'(r_idx) < STATE_ELEMS) n_state = S_X;
            S_X:    n_state = S_K;
            S_K:    n_state = S_KF;
            S_KF:   n_state = S_HD;
            S_HD:   n_state = S_HF;
            S_HF:   n_state = (r_i == 3'd1) ? S_EXP : S_HD;
            S_EXP:  n_state = S_DAH;
            S_DAH:  n_state = S_DTB;
            S_DTB:  n_state = S_DBU;
            S_DBU:  n_state = S_CH;
            S_CH:   n_state = r_last ? S_DU : S_OUT;
            S_DU:   n_state = S_OUT;
            S_OUT:  if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // per-state outputs: handshake, multiplier operands, memory write
    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        mem_we      = 1'b0;
        mul_a       = 34'sd0;
        mul_b       = 34'sd0;
        unique case (r_state)
            S_IDLE: i_in.ready = 1'b1;
            S_IDX: begin
                mul_a = 34'(r_dt);
                mul_b = 34'(r_a);
            end
            S_X: begin
                mul_a = x_n;
                mul_b = 34'(K_RECIP);
            end
            S_KF: begin
                mul_a = 34'(Q_ONE);
                mul_b = 34'(kf_r);
            end
            S_HD: begin
                mul_a = 34'($signed(hd_full[19:0]));
                mul_b = 34'(h_recip(r_i));
            end
            S_HF: begin
                mul_a = 34'(hf_p);
                mul_b = 34'(r_r);
            end
            S_EXP: begin
                mul_a = 34'(ex.val);
                mul_b = 34'(hprev);
            end
            S_DAH: begin
                mul_a = 34'(r_dt);
                mul_b = 34'(r_b);
            end
            S_DTB: begin
                mul_a = 34'(qr.val);
                mul_b = 34'(r_u);
            end
            S_DBU: begin
                mul_a  = 34'(r_c);
                mul_b  = 34'(ad.val);
                mem_we = 1'b1;
            end
            S_CH: begin
                mul_a = 34'(r_d);
                mul_b = 34'(r_u);
            end
            S_OUT: o_out.valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_out.new_state = r_new_state;
    assign o_out.out_value = r_out_value;
    assign o_out.out_valid = r_last;
    assign o_out.saturated = r_flag;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sum   <= 32'sd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CH) begin
                r_sum <= ad2.val;
            end else if (r_state == S_DU) begin
                r_sum <= 32'sd0;
            end
        end
    end

    // memory: registered read, write of the new element
    always_ff @(posedge i_clk) begin
        r_rd <= mem[addr];
        if (mem_we) begin
            mem[addr] <= ad.val;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_dt        <= i_in.step_size;
                r_u         <= i_in.sample_in;
                r_a         <= i_in.decay_coef;
                r_b         <= i_in.drive_coef;
                r_c         <= i_in.read_coef;
                r_d         <= i_in.skip_weight;
                r_h0        <= i_in.start_state;
                r_first     <= i_in.first_step;
                r_last      <= i_in.step_end;
                r_idx       <= i_in.elem_index;
                r_flag      <= 1'b0;
                r_out_value <= 32'sd0;
            end
            S_IDX: begin
                // modulo by repeated subtraction, only when depth < 16
                if (int'(r_idx) >= STATE_ELEMS) r_idx <= r_idx - 4'(STATE_ELEMS);
            end
            S_X: begin
                r_n    <= x_n;
                r_flag <= r_flag | qr.clip;
            end
            S_K:  r_q <= r_prod[48:31];
            S_KF: begin
                r_k <= kf_k;
                r_r <= 17'(kf_r);
                r_i <= 3'(H_TERMS);
            end
            S_HD: r_t <= hd_full[19:0];
            S_HF: begin
                r_p <= hf_p;
                r_i <= r_i - 3'd1;
            end
            S_EXP: r_flag <= r_flag | ex.clip;
            S_DAH: begin
                r_dah  <= qr.val;
                r_flag <= r_flag | qr.clip;
            end
            S_DTB: r_flag <= r_flag | qr.clip;
            S_DBU: begin
                r_new_state <= ad.val;
                r_flag      <= r_flag | qr.clip | ad.clip;
            end
            S_CH: r_flag <= r_flag | qr.clip | ad2.clip;
            S_DU: begin
                r_out_value <= ad2.val;
                r_flag      <= r_flag | qr.clip | ad2.clip;
            end
            default: begin
            end
        endcase
    end

endmodule
